[rtl/bfpa_pkg.sv]
// Shared types, command codes and width-series helpers for the bit-field packer.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package bfpa_pkg;

    localparam int VALUE_W = 64;
    localparam int WIDTH_W = 7;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADAPT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALIGN  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [WIDTH_W-1:0] width;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] word;
        logic [WIDTH_W-1:0] word_bits;
        logic               end_of_stream;
        logic               last_of_item;
    } res_t;

    // Adaptive width series: 4, 8, 12, 16, 24, 32, 40, ...
    function automatic int step_nb(input int i);
        int nb;
        nb = (i < 4) ? 4 * (i + 1) : 16 + 8 * (i - 3);
        return nb;
    endfunction

    // Number of series steps strictly below the word width.
    function automatic int max_steps(input int w);
        int cnt;
        cnt = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (step_nb(i) < w)
                cnt++;
        end
        return cnt;
    endfunction

endpackage

[rtl/bfpa_if.sv]
// Valid/ready channel interfaces for the packer's input and result streams.
// Depends on bfpa_pkg.
`timescale 1ns / 1ps

interface bfpa_in_if;
    logic                                valid;
    logic                                ready;
    logic [bfpa_pkg::CMD_W-1:0]          cmd;
    logic [bfpa_pkg::VALUE_W-1:0]        value;
    logic [bfpa_pkg::WIDTH_W-1:0]        width;

    modport source (output valid, output cmd, output value, output width, input ready);
    modport sink   (input valid, input cmd, input value, input width, output ready);
endinterface

interface bfpa_out_if;
    logic                                valid;
    logic                                ready;
    logic [bfpa_pkg::VALUE_W-1:0]        word;
    logic [bfpa_pkg::WIDTH_W-1:0]        word_bits;
    logic                                end_of_stream;
    logic                                last_of_item;

    modport source (output valid, output word, output word_bits, output end_of_stream,
                    output last_of_item, input ready);
    modport sink   (input valid, input word, input word_bits, input end_of_stream,
                    input last_of_item, output ready);
endinterface

[rtl/bit_field_packer_adaptive_core.sv]
// LSB-first bit-field packer with adaptive-width numbers, top level.
// Depends on bfpa_pkg, bfpa_if, bfpa_pack and bfpa_out_buf.
`timescale 1ns / 1ps

// Usage:
//   in_ch  (sink): cmd/value/width commands, taken when valid && ready.
//   out_ch (source): completed words with word_bits, end_of_stream and
//     last_of_item; a word moves when valid && ready.
//   Commands: write field, write adaptive number, byte align, finish.
//   A command is registered on acceptance and processed in the next cycle
//   unless it waits for output room; its words enter the output buffer at
//   that edge. One command per cycle is taken while none waits. A command
//   that completes two words waits until the registered buffer count shows
//   both output slots free, so back to back such commands wait until both
//   earlier words leave; a one-word command right behind one waits for a slot.
//   Commands that complete no word never wait on the output side.
//   When the receiver stalls, the two-entry output buffer and the input
//   register fill, then in_ch.ready drops; nothing is lost.
//   Reset empties both registers and clears the partial word, fill count
//   and byte position. Finish emits the partial word (possibly empty) with
//   end_of_stream set and returns to the reset state.
module bit_field_packer_adaptive_core #(
    parameter int WORD_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    bfpa_in_if.sink     in_ch,
    bfpa_out_if.source  out_ch
);
    import bfpa_pkg::*;

    localparam int FILL_W = $clog2(WORD_BITS);

    in_item_t           s1_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [WORD_BITS-1:0] partial_reg;
    logic [WORD_BITS-1:0] partial_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [2:0]         tot_reg;
    logic [2:0]         tot_next;
    logic [1:0]         n_res;
    res_t               res0;
    res_t               res1;
    logic [1:0]         buf_count;
    logic               proc;
    logic               in_fire;

    bfpa_pack #(.W(WORD_BITS)) u_pack (
        .item         (s1_reg),
        .partial      (partial_reg),
        .fill         (fill_reg),
        .tot          (tot_reg),
        .partial_next (partial_next),
        .fill_next    (fill_next),
        .tot_next     (tot_next),
        .n_res        (n_res),
        .res0         (res0),
        .res1         (res1)
    );

    // Room check uses the registered count only, keeping out_ch.ready off in_ch.ready.
    assign proc        = s1_valid_reg && (n_res <= (2'd2 - buf_count));
    assign in_ch.ready = !s1_valid_reg || proc;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (proc)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            partial_reg  <= '0;
            fill_reg     <= '0;
            tot_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (proc)
            begin
                partial_reg <= partial_next;
                fill_reg    <= fill_next;
                tot_reg     <= tot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg.cmd   <= in_ch.cmd;
            s1_reg.value <= in_ch.value;
            s1_reg.width <= in_ch.width;
        end
    end

    bfpa_out_buf u_out_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (proc),
        .n_push (n_res),
        .res0   (res0),
        .res1   (res1),
        .count  (buf_count),
        .out_ch (out_ch)
    );

    a_eos_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.end_of_stream |-> out_ch.last_of_item)
        else $error("finish word not marked last");

    a_mid_word_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.end_of_stream
        |-> out_ch.word_bits == WIDTH_W'(WORD_BITS))
        else $error("non-final word not full");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) < WORD_BITS)
        else $error("fill count reached word width");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc && s1_reg.cmd == CMD_FINISH |=> fill_reg == '0 && tot_reg == '0)
        else $error("finish did not clear state");

    a_word_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.word >> WORD_BITS) == '0)
        else $error("word has bits above word width");

endmodule

[rtl/bfpa_pack.sv]
// Packing datapath: builds the bit field for one command, merges it into the
// partial word and splits off completed words. Depends on bfpa_pkg.
`timescale 1ns / 1ps

module bfpa_pack #(
    parameter int W = 64
) (
    input  bfpa_pkg::in_item_t              item,
    input  logic [W-1:0]                    partial,
    input  logic [$clog2(W)-1:0]            fill,
    input  logic [2:0]                      tot,
    output logic [W-1:0]                    partial_next,
    output logic [$clog2(W)-1:0]            fill_next,
    output logic [2:0]                      tot_next,
    output logic [1:0]                      n_res,
    output bfpa_pkg::res_t                  res0,
    output bfpa_pkg::res_t                  res1
);
    import bfpa_pkg::*;

    localparam int FILL_W = $clog2(W);
    localparam int MAXS   = max_steps(W);
    localparam int ONES_W = $clog2(MAXS + 1);
    localparam int FLD_W  = W + MAXS + 1;
    localparam int LEN_W  = $clog2(FLD_W + 1);
    localparam int ACC_W  = W + FLD_W;
    localparam int SUM_W  = $clog2(W + FLD_W);
    localparam logic [WIDTH_W-1:0] W_WID = WIDTH_W'(W);

    logic [WIDTH_W-1:0] wsat;
    logic [W-1:0]       vm;
    logic [ONES_W-1:0]  ones;
    logic [LEN_W-1:0]   nb;
    logic               zbit;
    logic [FLD_W-1:0]   fld;
    logic [LEN_W-1:0]   len;
    logic [ACC_W-1:0]   acc;
    logic [SUM_W-1:0]   total;
    logic [ACC_W-1:0]   acc_w;
    logic [ACC_W-1:0]   acc_2w;

    assign vm   = item.value[W-1:0];
    assign wsat = (item.width > W_WID) ? W_WID : item.width;

    // Steps are monotone: the last threshold passed gives the count of 1 bits.
    always_comb
    begin
        ones = '0;
        for (int i = 0; i < MAXS; i++)
        begin
            if ((vm >> step_nb(i)) != '0)
                ones = ONES_W'(i + 1);
        end
    end

    always_comb
    begin
        nb   = LEN_W'(W);
        zbit = 1'b0;
        for (int i = 0; i <= MAXS; i++)
        begin
            if (ones == ONES_W'(i))
            begin
                nb   = (step_nb(i) > W) ? LEN_W'(W) : LEN_W'(step_nb(i));
                zbit = (step_nb(i) < W);
            end
        end
    end

    always_comb
    begin
        fld = '0;
        len = '0;
        unique case (item.cmd)
            CMD_WRITE:
            begin
                fld = FLD_W'(vm) & ~({FLD_W{1'b1}} << wsat);
                len = LEN_W'(wsat);
            end
            CMD_ADAPT:
            begin
                fld = ~({FLD_W{1'b1}} << ones)
                    | ((FLD_W'(vm) & ~({FLD_W{1'b1}} << nb))
                       << (LEN_W'(ones) + LEN_W'(zbit)));
                len = LEN_W'(ones) + LEN_W'(zbit) + nb;
            end
            CMD_ALIGN:
            begin
                fld = '0;
                len = LEN_W'(3'(~tot + 3'd1));
            end
            CMD_FINISH:
            begin
                fld = '0;
                len = '0;
            end
            default:
            begin
                fld = '0;
                len = '0;
            end
        endcase
    end

    assign acc    = ACC_W'(partial) | (ACC_W'(fld) << fill);
    assign total  = SUM_W'(fill) + SUM_W'(len);
    assign acc_w  = acc >> W;
    assign acc_2w = acc >> (2 * W);

    always_comb
    begin
        res0 = '0;
        res1 = '0;
        res0.word      = VALUE_W'(acc[W-1:0]);
        res0.word_bits = W_WID;
        res1.word      = VALUE_W'(acc[2*W-1:W]);
        res1.word_bits = W_WID;
        tot_next       = tot + len[2:0];
        if (item.cmd == CMD_FINISH)
        begin
            res0.word          = VALUE_W'(partial);
            res0.word_bits     = WIDTH_W'(fill);
            res0.end_of_stream = 1'b1;
            res0.last_of_item  = 1'b1;
            n_res        = 2'd1;
            partial_next = '0;
            fill_next    = '0;
            tot_next     = '0;
        end
        else if (total >= SUM_W'(2 * W))
        begin
            res1.last_of_item = 1'b1;
            n_res        = 2'd2;
            partial_next = acc_2w[W-1:0];
            fill_next    = FILL_W'(total - SUM_W'(2 * W));
        end
        else if (total >= SUM_W'(W))
        begin
            res0.last_of_item = 1'b1;
            n_res        = 2'd1;
            partial_next = acc_w[W-1:0];
            fill_next    = FILL_W'(total - SUM_W'(W));
        end
        else
        begin
            n_res        = 2'd0;
            partial_next = acc[W-1:0];
            fill_next    = FILL_W'(total);
        end
    end

endmodule

[rtl/bfpa_out_buf.sv]
// Two-entry result buffer driving the output channel; takes up to two words
// per push. Depends on bfpa_pkg and bfpa_out_if.
`timescale 1ns / 1ps

module bfpa_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [1:0]      n_push,
    input  bfpa_pkg::res_t  res0,
    input  bfpa_pkg::res_t  res1,
    output logic [1:0]      count,
    bfpa_out_if.source      out_ch
);
    import bfpa_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    res_t       e0_reg;
    res_t       e0_next;
    res_t       e1_reg;
    res_t       e1_next;
    logic       pop;
    logic [1:0] keep;

    assign pop  = (cnt_reg != 2'd0) && out_ch.ready;
    assign keep = cnt_reg - {1'b0, pop};

    always_comb
    begin
        e0_next = (pop && cnt_reg == 2'd2) ? e1_reg : e0_reg;
        e1_next = e1_reg;
        if (push && n_push != 2'd0)
        begin
            if (keep == 2'd0)
            begin
                e0_next = res0;
                e1_next = res1;
            end
            else
            begin
                e1_next = res0;
            end
        end
        cnt_next = keep + (push ? n_push : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign count                = cnt_reg;
    assign out_ch.valid         = (cnt_reg != 2'd0);
    assign out_ch.word          = e0_reg.word;
    assign out_ch.word_bits     = e0_reg.word_bits;
    assign out_ch.end_of_stream = e0_reg.end_of_stream;
    assign out_ch.last_of_item  = e0_reg.last_of_item;

endmodule
